>>> hw/rtl/p80enc_pkg.sv
// Package for the PRESENT-80 encryption core: block/key widths, the stage
// data type and the S-box, permutation and key-schedule functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package p80enc_pkg;

  localparam int unsigned BLK_W  = 64;
  localparam int unsigned KEY_W  = 80;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned KLO_W  = 16;

  // Register select is address bit 3 (registers sit at 8-byte spacing).
  localparam logic REG_KEY_HIGH = 1'b0;
  localparam logic REG_KEY_LOW  = 1'b1;

  typedef logic [3:0] nib_t;

  typedef struct packed {
    logic [BLK_W-1:0] state;
    logic [KEY_W-1:0] key;
  } blk_t;

  localparam nib_t SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  function automatic logic [BLK_W-1:0] sub_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = SBOX[s[4*n +: 4]];
    end
    return r;
  endfunction

  // Bit i moves to 16*i mod 63; bit 63 stays.
  function automatic logic [BLK_W-1:0] perm_layer(input logic [BLK_W-1:0] s);
    logic [BLK_W-1:0] r;
    r = '0;
    for (int i = 0; i < 63; i++) begin
      r[(16 * i) % 63] = s[i];
    end
    r[63] = s[63];
    return r;
  endfunction

  // Rotate left 61, S-box the top nibble, fold the round counter into 19..15.
  function automatic logic [KEY_W-1:0] round_key_step(input logic [KEY_W-1:0] k,
                                                     input logic [CNT_W-1:0] cnt);
    logic [KEY_W-1:0] r;
    r = {k[18:0], k[79:19]};
    r[79:76] = SBOX[r[79:76]];
    r[19:15] = r[19:15] ^ cnt;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/p80enc_if.sv
// Valid/ready channel interfaces for the PRESENT-80 encryption core:
// plaintext input channel and ciphertext result channel. Uses p80enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface p80enc_pt_if;
  logic                          valid;
  logic                          ready;
  logic [p80enc_pkg::BLK_W-1:0]  plaintext;

  modport source (output valid, output plaintext, input ready);
  modport sink   (input valid, input plaintext, output ready);
endinterface

interface p80enc_ct_if;
  logic                          valid;
  logic                          ready;
  logic [p80enc_pkg::BLK_W-1:0]  ciphertext;

  modport source (output valid, output ciphertext, input ready);
  modport sink   (input valid, input ciphertext, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/p80enc_round.sv
// One registered PRESENT round: key XOR, S-box layer, permutation, and the
// key-schedule step for round RND. Uses p80enc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module p80enc_round #(
  parameter int unsigned RND = 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               vld_in,
  input  wire p80enc_pkg::blk_t   blk_in,
  output logic                    vld_r,
  output p80enc_pkg::blk_t        blk_r
);
  import p80enc_pkg::*;

  localparam logic [CNT_W-1:0] RND_CNT = CNT_W'(RND);

  logic vld_nxt;
  blk_t blk_nxt;

  always_comb begin
    vld_nxt       = vld_in;
    blk_nxt.state = perm_layer(sub_layer(blk_in.state ^ blk_in.key[KEY_W-1 -: BLK_W]));
    blk_nxt.key   = round_key_step(blk_in.key, RND_CNT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Data needs no reset; hold while stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      blk_r <= blk_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/present80_encrypt_core.sv
// PRESENT-80 encryption core, top level. Uses p80enc_pkg, the channel
// interfaces in p80enc_if.sv and the round stage p80enc_round.
//
// Usage:
//   Load the 80-bit key through the APB-style port: key_high (key bits 79..16)
//   at byte address 0, key_low (key bits 15..0) at byte address 8. Writes
//   complete in the access cycle; pready is tied high. Write the key only
//   while no transaction is in flight.
//   Plaintext blocks enter on in_if (valid/ready); ciphertext leaves on out_if.
//   Each block passes through one register stage per round, each stage
//   carrying the block and its running key register, with the final key XOR
//   on the last stage's output.
//   Throughput is one block per cycle: all stages advance together on one
//   enable, so a block can enter in every cycle the output is not blocked.
//   When the receiver stalls and the last stage holds a block, the whole
//   pipeline holds and in_if.ready drops; nothing is lost or repeated.
//   Reset clears all stage valid bits and sets both key registers to zero.
`timescale 1ns / 1ps
`default_nettype none

module present80_encrypt_core #(
  parameter int unsigned ROUNDS = 31
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  p80enc_pt_if.sink                           in_if,
  p80enc_ct_if.source                         out_if,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [p80enc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [p80enc_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic      [p80enc_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                                cfg_pready
);
  import p80enc_pkg::*;

  logic [BLK_W-1:0] key_high_r;
  logic [KLO_W-1:0] key_low_r;
  logic             cfg_wr;
  logic             reg_sel;
  logic             en;
  logic             stg_vld [ROUNDS];
  blk_t             stg_blk [ROUNDS];
  blk_t             in_blk;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_KEY_HIGH: key_high_r <= cfg_pwdata;
        REG_KEY_LOW:  key_low_r  <= cfg_pwdata[KLO_W-1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_KEY_HIGH: cfg_prdata = key_high_r;
      REG_KEY_LOW:  cfg_prdata = {{(DATA_W-KLO_W){1'b0}}, key_low_r};
      default:      cfg_prdata = '0;
    endcase
  end

  // Advance the whole pipe unless the output holds a block nobody takes.
  assign en          = !stg_vld[ROUNDS-1] || out_if.ready;
  assign in_if.ready = en;

  assign in_blk.state = in_if.plaintext;
  assign in_blk.key   = {key_high_r, key_low_r};

  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    if (i == 0) begin : g_first
      p80enc_round #(.RND(i + 1)) u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_in (in_if.valid),
        .blk_in (in_blk),
        .vld_r  (stg_vld[i]),
        .blk_r  (stg_blk[i])
      );
    end else begin : g_next
      p80enc_round #(.RND(i + 1)) u_round (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_in (stg_vld[i-1]),
        .blk_in (stg_blk[i-1]),
        .vld_r  (stg_vld[i]),
        .blk_r  (stg_blk[i])
      );
    end
  end

  // Final round-key XOR.
  assign out_if.valid      = stg_vld[ROUNDS-1];
  assign out_if.ciphertext = stg_blk[ROUNDS-1].state
                             ^ stg_blk[ROUNDS-1].key[KEY_W-1 -: BLK_W];

endmodule

`default_nettype wire

>>> bench/present80_encrypt_core_tb.sv
`timescale 1ns / 1ps
// Testbench for present80_encrypt_core: PRESENT-80 encryption of plaintext blocks
// under keys loaded through the APB-style port, checked against a local cipher model.
// Depends on p80enc_pkg, p80enc_if.sv and the core RTL.

module present80_encrypt_core_tb;

  localparam int unsigned ROUNDS       = 31;
  localparam int unsigned SETTLE_CYC   = ROUNDS + 8;
  localparam int unsigned BLK_W        = p80enc_pkg::BLK_W;
  localparam int unsigned KLO_W        = p80enc_pkg::KLO_W;

  localparam logic [3:0] PRESENT_SBOX [16] = '{
    4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
    4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  localparam logic [BLK_W-1:0] ALL_ONES = {BLK_W{1'b1}};

  logic clk = 1'b0;
  logic rst_n;

  logic                             cfg_psel;
  logic                             cfg_penable;
  logic                             cfg_pwrite;
  logic [p80enc_pkg::ADDR_W-1:0]    cfg_paddr;
  logic [p80enc_pkg::DATA_W-1:0]    cfg_pwdata;
  logic [p80enc_pkg::DATA_W-1:0]    cfg_prdata;
  logic                             cfg_pready;

  p80enc_pt_if in_ch ();
  p80enc_ct_if out_ch ();

  // Key as the core should hold it
  logic [BLK_W-1:0]  key_hi_q;
  logic [KLO_W-1:0]  key_lo_q;

  logic [BLK_W-1:0]  ct_expected [$];
  bit                in_idle_en;
  bit                out_idle_en;
  int                error_count;
  int                blocks_sent;
  int                blocks_checked;
  int                key_settings;

  present80_encrypt_core #(.ROUNDS(ROUNDS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  function automatic logic [BLK_W-1:0] present_encrypt(input logic [BLK_W-1:0] pt);
    logic [79:0]      k;
    logic [BLK_W-1:0] s;
    logic [BLK_W-1:0] t;
    logic [BLK_W-1:0] p;
    logic [4:0]       rc;
    k = {key_hi_q, key_lo_q};
    s = pt;
    for (int r = 1; r <= ROUNDS; r++) begin
      s = s ^ k[79:16];
      for (int n = 0; n < 16; n++) begin
        t[4*n +: 4] = PRESENT_SBOX[s[4*n +: 4]];
      end
      p = '0;
      for (int i = 0; i < 63; i++) begin
        p[(16 * i) % 63] = t[i];
      end
      p[63] = t[63];
      s = p;
      // rotate the 80-bit key left by 61, substitute top nibble, fold in counter
      rc = r[4:0];
      k = {k[18:0], k[79:19]};
      k[79:76] = PRESENT_SBOX[k[79:76]];
      k[19:15] = k[19:15] ^ rc;
    end
    return s ^ k[79:16];
  endfunction

  task automatic report_mismatch(input string what, input logic [BLK_W-1:0] got,
                                 input logic [BLK_W-1:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Check each ciphertext transaction against the oldest prediction
  always @(posedge clk) begin : check_ciphertext
    logic [BLK_W-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (ct_expected.size() == 0) begin
        report_mismatch("ciphertext with no block pending", out_ch.ciphertext, 'x);
      end else begin
        want = ct_expected.pop_front();
        if (out_ch.ciphertext !== want) begin
          report_mismatch("ciphertext", out_ch.ciphertext, want);
        end
        blocks_checked++;
      end
    end
  end

  // Result side: stall in random bursts while enabled
  initial begin : drive_ready
    int n;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (out_idle_en && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_block(input logic [BLK_W-1:0] pt);
    int gap;
    @(negedge clk);
    if (in_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid     <= 1'b0;
      in_ch.plaintext <= {$urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.plaintext <= pt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ct_expected.push_back(present_encrypt(pt));
    blocks_sent++;
  endtask

  task automatic wait_results;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (ct_expected.size() != 0) @(posedge clk);
  endtask

  // Drain the pipeline fully before touching the key
  task automatic settle_idle;
    wait_results();
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write one key register, then read it back
  task automatic access_key_reg(input logic sel, input logic [BLK_W-1:0] value);
    logic [p80enc_pkg::DATA_W-1:0] readback;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 3'b000};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (sel == p80enc_pkg::REG_KEY_HIGH) begin
      key_hi_q = value;
    end else begin
      key_lo_q = value[KLO_W-1:0];
    end
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (sel == p80enc_pkg::REG_KEY_HIGH) begin
      if (readback !== key_hi_q) report_mismatch("key_high readback", readback, key_hi_q);
    end else if (readback[KLO_W-1:0] !== key_lo_q) begin
      report_mismatch("key_low readback", readback, {48'b0, key_lo_q});
    end
  endtask

  task automatic load_key(input logic [BLK_W-1:0] hi, input logic [BLK_W-1:0] lo);
    access_key_reg(p80enc_pkg::REG_KEY_HIGH, hi);
    access_key_reg(p80enc_pkg::REG_KEY_LOW, lo);
    key_settings++;
  endtask

  task automatic check_vector(input logic [BLK_W-1:0] pt, input logic [BLK_W-1:0] ct);
    if (present_encrypt(pt) !== ct) report_mismatch("model vector", present_encrypt(pt), ct);
  endtask

  // Published vectors under the all-zero and all-ones keys, then odd patterns
  task automatic test_known_answers;
    logic [BLK_W-1:0] patterns [5];
    patterns = '{64'h0123_4567_89AB_CDEF, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000, 64'h1};
    // key registers come out of reset as zero
    check_vector('0, 64'h5579_C138_7B22_8445);
    check_vector(ALL_ONES, 64'hA112_FFC7_2F68_417B);
    send_block('0);
    send_block(ALL_ONES);
    settle_idle();
    // key_low written with junk above bit 15, which must be dropped
    load_key(ALL_ONES, ALL_ONES);
    check_vector('0, 64'hE72C_46C0_F594_5049);
    check_vector(ALL_ONES, 64'h3333_DCD3_2132_10D2);
    send_block('0);
    send_block(ALL_ONES);
    foreach (patterns[i]) send_block(patterns[i]);
    settle_idle();
  endtask

  task automatic test_key_extremes;
    settle_idle();
    load_key('0, 64'hFFFF);
    send_block('0);
    send_block(ALL_ONES);
    send_block(64'h8000_0000_0000_0001);
    send_block(64'h7FFF_FFFF_FFFF_FFFE);
    settle_idle();
    load_key(64'h8000_0000_0000_0000, 64'hFFFF_0000_0000_0001);
    send_block('0);
    send_block(ALL_ONES);
    send_block(64'hF0F0_F0F0_0F0F_0F0F);
    send_block(64'h0000_0001_0000_0000);
    settle_idle();
  endtask

  task automatic test_random_keys;
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    for (int k = 0; k < 4; k++) begin
      settle_idle();
      load_key({$urandom, $urandom}, {$urandom, $urandom});
      for (int n = 0; n < 80; n++) begin
        // hold the sender until the pipeline has emptied once
        if (k == 1 && n == 40) wait_results();
        send_block({$urandom, $urandom});
      end
    end
  endtask

  task automatic test_streaming;
    settle_idle();
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    load_key({$urandom, $urandom}, {$urandom, $urandom});
    for (int n = 0; n < 130; n++) send_block({$urandom, $urandom});
  endtask

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.plaintext = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    key_hi_q        = '0;
    key_lo_q        = '0;
    in_idle_en      = 1'b0;
    out_idle_en     = 1'b0;
    error_count     = 0;
    blocks_sent     = 0;
    blocks_checked  = 0;
    key_settings    = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_known_answers();
    test_key_extremes();
    test_random_keys();
    test_streaming();

    wait_results();
    repeat (SETTLE_CYC) @(posedge clk);
    $display("Encrypted %0d blocks under %0d keys, %0d ciphertexts compared,",
             blocks_sent, key_settings, blocks_checked);
    $display("with random stalls on both channels and a back-to-back stream at the end.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Timeout with %0d ciphertexts still pending", ct_expected.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
